// ===== rtl/core/nsr_pkg.sv =====
// Shared constants and the per-stage record of the square-root cell chain.
package nsr_pkg;

    localparam int DATA_W         = 32;               // operand and root width
    localparam int FRAC_W         = 16;               // fraction bits of Q16.16
    localparam int QUO_W          = 32;               // quotient bits kept per step
    localparam int ITERATIONS_DEF = 20;               // default Newton step count
    localparam int CELLS_PER_ITER = QUO_W + 2;        // start, bit cells, update

    // Data handed from one cell to the next.
    typedef struct packed {
        logic                valid;  // stage holds an item
        logic                pos;    // operand was strictly positive
        logic [DATA_W-2:0]   raw;    // operand bits below the sign bit
        logic [DATA_W-1:0]   est;    // current root estimate, unsigned Q16.16
        logic [QUO_W-1:0]    rem;    // partial remainder of the running division
        logic [QUO_W-1:0]    quo;    // quotient bits developed so far, MSB first
        logic                ovf;    // quotient does not fit in QUO_W bits
    } t_cell;

endpackage

// ===== rtl/core/newton_square_root_core.sv =====
// The root passes through every cell of the chain and then through the output register.
// Throughput: one operand per cycle while the chain is not stalled; every cell of the chain advances together.
// Each Newton step is 34 cells: overflow set-up, 32 restoring division bit cells, update.
// The chain stalls only when the output register holds an untaken root and the last cell
// is occupied; an empty last cell lets the chain keep moving to close bubbles.
// Reset (synchronous, active low) clears every valid bit; payload registers are not reset.
module newton_square_root_core #(
    parameter int ITERATIONS = nsr_pkg::ITERATIONS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // operand channel
    input  logic                       i_operand_valid,
    output logic                       o_operand_ready,
    input  logic signed [nsr_pkg::DATA_W-1:0] i_operand,
    // root channel
    output logic                       o_root_valid,
    input  logic                       i_root_ready,
    output logic [nsr_pkg::DATA_W-1:0] o_root
);

    // Cell records between iterations; entry 0 is the formatted operand.
    nsr_pkg::t_cell w_link [0:ITERATIONS];

    logic                         w_en;
    logic                         w_out_load;
    logic                         r_root_valid;
    logic [nsr_pkg::DATA_W-1:0]   r_root;

    // Output register is free when empty or when its root transfers this cycle.
    assign w_out_load = !r_root_valid || i_root_ready;

    // Advance the chain when the tail can drain, or when the tail is a bubble.
    assign w_en = w_out_load || !w_link[ITERATIONS].valid;

    assign o_operand_ready = w_en;

    // Format the incoming operand. A non-positive operand still flows through
    // the chain; drop its estimate at the output instead.
    always_comb begin
        w_link[0]       = '0;
        w_link[0].valid = i_operand_valid;
        w_link[0].pos   = !i_operand[nsr_pkg::DATA_W-1] && (i_operand != '0);
        w_link[0].raw   = i_operand[nsr_pkg::DATA_W-2:0];
        w_link[0].est   = i_operand;   // start the estimate at the operand
    end

    genvar g;
    generate
        for (g = 0; g < ITERATIONS; g++) begin : g_iter
            nsr_iteration u_iter (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_cell  (w_link[g]),
                .o_cell  (w_link[g+1])
            );
        end
    endgenerate

    // Output register: hold the root until it transfers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_valid <= 1'b0;
        end else if (w_out_load) begin
            r_root_valid <= w_link[ITERATIONS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_root <= w_link[ITERATIONS].pos ? w_link[ITERATIONS].est : '0;
        end
    end

    assign o_root_valid = r_root_valid;
    assign o_root       = r_root;

endmodule

// ===== rtl/core/nsr_start_cell.sv =====
// Division set-up cell: checks quotient overflow and seeds the remainder.
module nsr_start_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  nsr_pkg::t_cell i_cell,
    output nsr_pkg::t_cell o_cell
);

    localparam int HI_W = nsr_pkg::DATA_W - 1 - nsr_pkg::FRAC_W;

    logic [HI_W-1:0]      w_hi;
    nsr_pkg::t_cell       n_cell;
    nsr_pkg::t_cell       r_cell;
    logic                 r_valid;

    // Upper dividend word: dividend is operand << 16, so bits 46:32 are operand 30:16.
    assign w_hi = i_cell.raw[nsr_pkg::DATA_W-2:nsr_pkg::FRAC_W];

    always_comb begin
        n_cell     = i_cell;
        n_cell.ovf = ({{(nsr_pkg::DATA_W-HI_W){1'b0}}, w_hi} >= i_cell.est);
        n_cell.rem = {{(nsr_pkg::QUO_W-HI_W){1'b0}}, w_hi};
        n_cell.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    always_comb begin
        o_cell       = r_cell;
        o_cell.valid = r_valid;
    end

endmodule

// ===== rtl/core/nsr_div_cell.sv =====
// Restoring division cell: develops one quotient bit per stage.
module nsr_div_cell #(
    parameter int BIT = nsr_pkg::QUO_W - 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  nsr_pkg::t_cell i_cell,
    output nsr_pkg::t_cell o_cell
);

    logic                    w_dbit;
    logic [nsr_pkg::QUO_W:0] w_trial;
    logic [nsr_pkg::QUO_W:0] w_diff;
    logic                    w_take;
    nsr_pkg::t_cell          n_cell;
    nsr_pkg::t_cell          r_cell;
    logic                    r_valid;

    // Dividend bit BIT: low 16 bits of the shifted operand are zero.
    generate
        if (BIT >= nsr_pkg::FRAC_W) begin : g_opbit
            assign w_dbit = i_cell.raw[BIT-nsr_pkg::FRAC_W];
        end else begin : g_zero
            assign w_dbit = 1'b0;
        end
    endgenerate

    assign w_trial = {i_cell.rem, w_dbit};
    assign w_diff  = w_trial - {1'b0, i_cell.est};
    assign w_take  = (w_trial >= {1'b0, i_cell.est});

    always_comb begin
        n_cell     = i_cell;
        n_cell.rem = w_take ? w_diff[nsr_pkg::QUO_W-1:0] : w_trial[nsr_pkg::QUO_W-1:0];
        n_cell.quo = {i_cell.quo[nsr_pkg::QUO_W-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    always_comb begin
        o_cell       = r_cell;
        o_cell.valid = r_valid;
    end

endmodule

// ===== rtl/core/nsr_update_cell.sv =====
// Newton update cell: new estimate is (estimate + quotient) / 2.
module nsr_update_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  nsr_pkg::t_cell i_cell,
    output nsr_pkg::t_cell o_cell
);

    logic [nsr_pkg::QUO_W-1:0]  w_quo;
    logic [nsr_pkg::DATA_W:0]   w_sum;
    nsr_pkg::t_cell             n_cell;
    nsr_pkg::t_cell             r_cell;
    logic                       r_valid;

    // Saturate the quotient when it overflows (covers a zero estimate too).
    assign w_quo = i_cell.ovf ? {nsr_pkg::QUO_W{1'b1}} : i_cell.quo;
    assign w_sum = {1'b0, i_cell.est} + {1'b0, w_quo};

    always_comb begin
        n_cell     = i_cell;
        n_cell.est = w_sum[nsr_pkg::DATA_W:1];
        n_cell.rem = '0;
        n_cell.quo = '0;
        n_cell.ovf = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    always_comb begin
        o_cell       = r_cell;
        o_cell.valid = r_valid;
    end

endmodule

// ===== rtl/core/nsr_iteration.sv =====
// One Newton step: set-up cell, a row of division bit cells, update cell.
module nsr_iteration (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  nsr_pkg::t_cell i_cell,
    output nsr_pkg::t_cell o_cell
);

    nsr_pkg::t_cell w_link [0:nsr_pkg::QUO_W];

    nsr_start_cell u_start (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_cell  (i_cell),
        .o_cell  (w_link[0])
    );

    genvar g;
    generate
        for (g = 0; g < nsr_pkg::QUO_W; g++) begin : g_bit
            nsr_div_cell #(
                .BIT (nsr_pkg::QUO_W - 1 - g)
            ) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (i_en),
                .i_cell  (w_link[g]),
                .o_cell  (w_link[g+1])
            );
        end
    endgenerate

    nsr_update_cell u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_cell  (w_link[nsr_pkg::QUO_W]),
        .o_cell  (o_cell)
    );

endmodule

// ===== rtl/core/nsr_checker.sv =====
// Port-level checker for the square-root core, with its bind.
module nsr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_operand_valid,
    input logic                       o_operand_ready,
    input logic [nsr_pkg::DATA_W-1:0] i_operand,
    input logic                       o_root_valid,
    input logic                       i_root_ready,
    input logic [nsr_pkg::DATA_W-1:0] o_root
);

    // A stalled root holds its value.
    a_root_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_root_valid && !i_root_ready |=> o_root_valid && $stable(o_root))
        else $error("root changed or dropped while stalled");

    // A waiting operand holds its value until it transfers.
    a_operand_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_operand_valid && !o_operand_ready |=> i_operand_valid && $stable(i_operand))
        else $error("operand changed or dropped while waiting");

    // Reset empties the output.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_root_valid)
        else $error("root valid after reset");

    // An empty output register never blocks the operand side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_root_valid |-> o_operand_ready)
        else $error("operand side stalled with empty output");

    // Any Newton step from a 31-bit operand lands below 2^31.
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_root_valid |-> !o_root[nsr_pkg::DATA_W-1])
        else $error("root out of range");

endmodule

bind newton_square_root_core nsr_checker u_nsr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_operand_valid (i_operand_valid),
    .o_operand_ready (o_operand_ready),
    .i_operand       (i_operand),
    .o_root_valid    (o_root_valid),
    .i_root_ready    (i_root_ready),
    .o_root          (o_root)
);
